// File: hw/rtl/stpq_pkg.sv
// Shared types, constants and the ordering function for the sorted incident queue.
// Used by stpq_cell and severity_time_priority_queue; depends on nothing else.
package stpq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int FILL_W      = 5;

  typedef enum logic [1:0] {
    ACT_ENQ  = 2'd0,
    ACT_DEQ  = 2'd1,
    ACT_PEEK = 2'd2
  } act_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INS,
    CMD_POP
  } cmd_t;

  typedef struct packed {
    logic [7:0]  place;
    logic [1:0]  utype;
    logic [15:0] id;
    logic [31:0] rtime;
    logic [7:0]  sev;
  } rec_t;

  typedef struct packed {
    cmd_t cmd;
    rec_t rec;
  } cell_ctl_t;

  // True when record a must be served ahead of record b.
  function automatic logic goes_before(rec_t a, rec_t b);
    return {a.sev, ~a.rtime} > {b.sev, ~b.rtime};
  endfunction

endpackage

// File: hw/rtl/stpq_cell.sv
// One slot of the sorted queue: holds a record and its valid bit.
// Depends on stpq_pkg; instantiated in a row by severity_time_priority_queue.
module stpq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  stpq_pkg::cell_ctl_t ctl,
  input  logic               prev_ins,
  input  stpq_pkg::rec_t     prev_rec,
  input  logic               prev_vld,
  input  stpq_pkg::rec_t     next_rec,
  input  logic               next_vld,
  output logic               ins,
  output stpq_pkg::rec_t     rec,
  output logic               vld
);

  stpq_pkg::rec_t rec_r, rec_nxt;
  logic           vld_r, vld_nxt;

  // The new record belongs at or ahead of this slot.
  assign ins = !vld_r || stpq_pkg::goes_before(ctl.rec, rec_r);
  assign rec = rec_r;
  assign vld = vld_r;

  always_comb begin
    rec_nxt = rec_r;
    vld_nxt = vld_r;
    unique case (ctl.cmd)
      stpq_pkg::CMD_INS: begin
        if (ins && !prev_ins) begin
          rec_nxt = ctl.rec;
          vld_nxt = 1'b1;
        end else if (ins) begin
          rec_nxt = prev_rec;
          vld_nxt = prev_vld;
        end
      end
      stpq_pkg::CMD_POP: begin
        rec_nxt = next_rec;
        vld_nxt = next_vld;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

endmodule

// File: hw/rtl/severity_time_priority_queue.sv
// Top level of the sorted incident queue: handshake, entry count and result register.
// Depends on stpq_pkg and a row of stpq_cell slots.
//
// Usage: each input word is one action, chosen by in_tuser: enqueue a record,
// dequeue the head record or peek at it. Every accepted word yields exactly one
// result word. Records are kept sorted across a row of cells, head in cell zero:
// higher severity first, then earlier report time, then arrival order.
// Every cell compares the incoming record against its own in parallel and the
// whole row shifts by one slot in the same cycle. The result is registered and
// appears in the cycle after the input word is accepted; one word per cycle is
// sustained while the receiver keeps out_tready high. The rate is set by the
// parallel compare-and-shift of the cell row.
// A dequeue or peek on an empty queue reports the empty status with a zero
// record; an enqueue to a full queue is dropped and reports the full status.
// Reset clears the entry count, all cell valid bits and the result valid flag.
// When the receiver stalls, the result word holds on out_tdata and in_tready
// drops until that word is taken; a new word is accepted in the same cycle as
// the held result leaves.
module severity_time_priority_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [7:0] severity, [39:8] report_time, [55:40] incident_id,
  // [57:56] unit_type, [65:58] place, [71:66] zero
  input  logic [71:0] in_tdata,
  // [1:0] action
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] out_severity, [39:8] out_time, [55:40] out_id, [57:56] out_type,
  // [65:58] out_place, [66] is_empty, [71:67] fill_count
  output logic [71:0] out_tdata,
  // [1:0] status
  output logic [1:0]  out_tuser
);

  localparam int D = stpq_pkg::QUEUE_DEPTH;

  stpq_pkg::rec_t      in_rec;
  stpq_pkg::cell_ctl_t ctl;
  stpq_pkg::rec_t      cell_rec [D];
  logic [D-1:0]        cell_vld;
  logic [D-1:0]        cell_ins;

  logic [stpq_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [stpq_pkg::CNT_W+4:0]   count_ext;
  logic                         out_valid_r;
  stpq_pkg::status_t            status_r, status_nxt;
  stpq_pkg::rec_t               head_r, head_nxt;
  logic                         empty_r;
  logic [stpq_pkg::FILL_W-1:0]  fill_r;
  logic                         accept;

  assign in_rec.sev   = in_tdata[7:0];
  assign in_rec.rtime = in_tdata[39:8];
  assign in_rec.id    = in_tdata[55:40];
  assign in_rec.utype = in_tdata[57:56];
  assign in_rec.place = in_tdata[65:58];

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // Decode the action into a row command and the result fields.
  always_comb begin
    ctl.rec    = in_rec;
    ctl.cmd    = stpq_pkg::CMD_HOLD;
    count_nxt  = count_r;
    status_nxt = stpq_pkg::ST_OK;
    head_nxt   = '0;
    if (accept) begin
      unique case (in_tuser)
        stpq_pkg::ACT_ENQ: begin
          if (count_r == stpq_pkg::CNT_W'(D)) begin
            status_nxt = stpq_pkg::ST_FULL;
          end else begin
            ctl.cmd   = stpq_pkg::CMD_INS;
            count_nxt = count_r + 1'b1;
          end
        end
        stpq_pkg::ACT_DEQ, stpq_pkg::ACT_PEEK: begin
          if (count_r == '0) begin
            status_nxt = stpq_pkg::ST_EMPTY;
          end else begin
            head_nxt = cell_rec[0];
            if (in_tuser == stpq_pkg::ACT_DEQ) begin
              ctl.cmd   = stpq_pkg::CMD_POP;
              count_nxt = count_r - 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign count_ext = {5'b0, count_nxt};

  // Row of cells; each one trades records with its neighbors on an insert or a pop.
  for (genvar i = 0; i < D; i++) begin : g_cell
    stpq_pkg::rec_t prev_rec, next_rec;
    logic           prev_vld, next_vld, prev_ins;
    if (i == 0) begin : g_first
      assign prev_rec = '0;
      assign prev_vld = 1'b0;
      assign prev_ins = 1'b0;
    end else begin : g_mid
      assign prev_rec = cell_rec[i-1];
      assign prev_vld = cell_vld[i-1];
      assign prev_ins = cell_ins[i-1];
    end
    if (i == D - 1) begin : g_last
      assign next_rec = '0;
      assign next_vld = 1'b0;
    end else begin : g_inner
      assign next_rec = cell_rec[i+1];
      assign next_vld = cell_vld[i+1];
    end
    stpq_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .prev_ins (prev_ins),
      .prev_rec (prev_rec),
      .prev_vld (prev_vld),
      .next_rec (next_rec),
      .next_vld (next_vld),
      .ins      (cell_ins[i]),
      .rec      (cell_rec[i]),
      .vld      (cell_vld[i])
    );
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      head_r   <= head_nxt;
      empty_r  <= (count_nxt == '0);
      fill_r   <= count_ext[stpq_pkg::FILL_W-1:0];
    end
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {fill_r, empty_r, head_r.place, head_r.utype, head_r.id,
                       head_r.rtime, head_r.sev};

`ifndef SYNTH
  // The number of occupied cells always matches the entry count.
  a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_vld) == 32'(count_r))
    else $error("cell valid bits disagree with entry count");

  // The count never exceeds the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= stpq_pkg::CNT_W'(D))
    else $error("entry count exceeds depth");

  // Occupied cells form a prefix of the row: head valid whenever count is nonzero.
  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) == cell_vld[0])
    else $error("head cell validity disagrees with entry count");

  // A stalled result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !accept)
    else $error("input accepted while result stalled");
`endif

endmodule

// File: bench/tb.sv
// Self-checking bench for the sorted incident queue: stream driver, result monitor
// and a cycle-free software copy of the queue. Depends on stpq_pkg and the RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // The package names only the three real actions; the fourth code is a no-op.
  localparam logic [1:0] ACT_NONE = 2'd3;

  // First word of the stretch without random idles or back-pressure, and its length.
  localparam int STEADY_FIRST = 220;
  localparam int STEADY_LEN   = 130;

  // One incident record as the bench sees it.
  typedef struct packed {
    logic [7:0]  sev;
    logic [31:0] rtime;
    logic [15:0] id;
    logic [1:0]  utype;
    logic [7:0]  place;
  } incident_t;

  // One action word waiting to be driven. When wait_drain is set the sender
  // holds this word back until every outstanding result has come back.
  typedef struct {
    logic [1:0] action;
    incident_t  rec;
    bit         wait_drain;
  } action_word_t;

  // One result word as it should appear on the output.
  typedef struct {
    stpq_pkg::status_t status;
    incident_t         head;
    logic              empty;
    logic [4:0]        fill;
  } queue_reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic [1:0]  in_tuser = ACT_NONE;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic [1:0]  out_tuser;

  severity_time_priority_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #10 clk = ~clk;

  // Stimulus not yet driven, and replies predicted but not yet seen.
  action_word_t pending_words[$];
  queue_reply_t awaited_replies[$];
  action_word_t word_on_bus;
  int           words_sent = 0;
  int           errors = 0;
  bit           steady;

  // Software copy of the queue: sorted, head at index zero.
  incident_t    sorted_recs[stpq_pkg::QUEUE_DEPTH];
  int           held = 0;

  assign steady = (words_sent >= STEADY_FIRST) && (words_sent < STEADY_FIRST + STEADY_LEN);

  // Higher severity wins; on equal severity the earlier report time wins.
  // Full ties return false, so a newcomer lands behind its equals and
  // arrival order is kept.
  function automatic bit outranks(incident_t a, incident_t b);
    if (a.sev != b.sev) return a.sev > b.sev;
    return a.rtime < b.rtime;
  endfunction

  // Apply one action to the software queue and return the reply it must give.
  function automatic queue_reply_t serve_action(action_word_t w);
    queue_reply_t r;
    int           slot;
    bit           found;
    r.status = stpq_pkg::ST_OK;
    r.head   = '0;
    found    = 1'b0;
    slot     = held;
    if (w.action == stpq_pkg::ACT_ENQ) begin
      if (held >= stpq_pkg::QUEUE_DEPTH) begin
        r.status = stpq_pkg::ST_FULL;
      end else begin
        for (int i = 0; i < held; i++) begin
          if (!found && outranks(w.rec, sorted_recs[i])) begin
            slot  = i;
            found = 1'b1;
          end
        end
        for (int i = held; i > slot; i--) sorted_recs[i] = sorted_recs[i-1];
        sorted_recs[slot] = w.rec;
        held++;
      end
    end else if (w.action == stpq_pkg::ACT_DEQ || w.action == stpq_pkg::ACT_PEEK) begin
      if (held == 0) begin
        r.status = stpq_pkg::ST_EMPTY;
      end else begin
        r.head = sorted_recs[0];
        if (w.action == stpq_pkg::ACT_DEQ) begin
          for (int i = 1; i < held; i++) sorted_recs[i-1] = sorted_recs[i];
          held--;
        end
      end
    end
    r.empty = (held == 0);
    r.fill  = held[4:0];
    return r;
  endfunction

  function automatic void check_field(string name, longint unsigned want,
                                      longint unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Driver. When the word on the bus is taken, its reply is predicted at once.
  // A new word goes out only when the bus is free, the sender is not pausing
  // for a drain, and the random idle draw allows it (never in the steady stretch).
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        awaited_replies.push_back(serve_action(word_on_bus));
        words_sent++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_words.size() > 0 &&
            !(pending_words[0].wait_drain && awaited_replies.size() != 0) &&
            (steady || $urandom_range(99) >= 38)) begin
          word_on_bus = pending_words.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= word_on_bus.action;
          in_tdata  <= {6'b0, word_on_bus.rec.place, word_on_bus.rec.utype,
                        word_on_bus.rec.id, word_on_bus.rec.rtime, word_on_bus.rec.sev};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure outside the steady stretch, and a
  // field-by-field compare of each taken word against the oldest prediction.
  always @(posedge clk) begin
    queue_reply_t want;
    out_tready <= steady || ($urandom_range(99) >= 38);
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_replies.size() == 0) begin
        $display("%0t: result word with none expected, actual tuser 0x%0h tdata 0x%0h",
                 $time, out_tuser, out_tdata);
        errors++;
      end else begin
        want = awaited_replies.pop_front();
        check_field("status",       want.status,     out_tuser);
        check_field("out_severity", want.head.sev,   out_tdata[7:0]);
        check_field("out_time",     want.head.rtime, out_tdata[39:8]);
        check_field("out_id",       want.head.id,    out_tdata[55:40]);
        check_field("out_type",     want.head.utype, out_tdata[57:56]);
        check_field("out_place",    want.head.place, out_tdata[65:58]);
        check_field("is_empty",     want.empty,      out_tdata[66]);
        check_field("fill_count",   want.fill,       out_tdata[71:67]);
      end
    end
  end

  function automatic void add_word(logic [1:0] act, incident_t rec, bit drain);
    action_word_t w;
    w.action     = act;
    w.rec        = rec;
    w.wait_drain = drain;
    pending_words.push_back(w);
  endfunction

  function automatic incident_t make_rec(logic [7:0] sev, logic [31:0] rtime,
                                         logic [15:0] id, logic [1:0] utype,
                                         logic [7:0] place);
    incident_t r;
    r.sev = sev; r.rtime = rtime; r.id = id; r.utype = utype; r.place = place;
    return r;
  endfunction

  // Random record. Severity and time are often drawn from a narrow set so that
  // equal severities and full key ties show up regularly.
  function automatic incident_t random_rec();
    incident_t r;
    case ($urandom_range(3))
      0:       r.sev = $urandom_range(1) ? 8'hFF : 8'h00;
      1:       r.sev = 8'd100 + 8'($urandom_range(2));
      default: r.sev = 8'($urandom);
    endcase
    case ($urandom_range(3))
      0:       r.rtime = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      1:       r.rtime = 32'd5000 + 32'($urandom_range(2));
      default: r.rtime = $urandom;
    endcase
    r.id    = 16'($urandom);
    r.utype = 2'($urandom);
    r.place = 8'($urandom);
    return r;
  endfunction

  // Pick an action from percentage weights for enqueue, dequeue and peek;
  // whatever is left over becomes the unused code.
  function automatic logic [1:0] pick_action(int w_enq, int w_deq, int w_peek);
    int roll;
    roll = $urandom_range(99);
    if (roll < w_enq) return stpq_pkg::ACT_ENQ;
    if (roll < w_enq + w_deq) return stpq_pkg::ACT_DEQ;
    if (roll < w_enq + w_deq + w_peek) return stpq_pkg::ACT_PEEK;
    return ACT_NONE;
  endfunction

  initial begin
    incident_t zero_rec;
    int        phase_kind;
    int        phase_len;
    zero_rec = '0;

    // Directed part. An empty queue answers peek and dequeue with the empty
    // status, and the unused action with a zero record.
    add_word(stpq_pkg::ACT_PEEK, zero_rec, 1'b0);
    add_word(stpq_pkg::ACT_DEQ,  zero_rec, 1'b0);
    add_word(ACT_NONE, make_rec(8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 2'd3, 8'hFF), 1'b0);
    // Field extremes, then keys that tie on severity and tie completely.
    add_word(stpq_pkg::ACT_ENQ,
             make_rec(8'h00, 32'h0000_0000, 16'h0000, 2'd0, 8'h00), 1'b0);
    add_word(stpq_pkg::ACT_ENQ,
             make_rec(8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 2'd3, 8'hFF), 1'b0);
    add_word(stpq_pkg::ACT_ENQ,
             make_rec(8'hFF, 32'h0000_0000, 16'h0001, 2'd1, 8'h55), 1'b0);
    add_word(stpq_pkg::ACT_ENQ,
             make_rec(8'hFF, 32'h0000_0000, 16'h0002, 2'd2, 8'hAA), 1'b0);
    add_word(stpq_pkg::ACT_ENQ,
             make_rec(8'h80, 32'h0000_0005, 16'h1234, 2'd1, 8'h0F), 1'b0);
    add_word(stpq_pkg::ACT_ENQ,
             make_rec(8'h80, 32'h0000_0004, 16'h4321, 2'd2, 8'hF0), 1'b0);
    add_word(ACT_NONE, zero_rec, 1'b0);
    add_word(stpq_pkg::ACT_PEEK, zero_rec, 1'b0);
    repeat (6) add_word(stpq_pkg::ACT_DEQ, zero_rec, 1'b0);
    add_word(stpq_pkg::ACT_DEQ,  zero_rec, 1'b0);
    add_word(stpq_pkg::ACT_PEEK, zero_rec, 1'b0);

    // Random part in phases: filling phases push the queue to full and past
    // it, draining phases empty it again, mixed phases churn the middle.
    // The first random word and some phase starts wait for a full drain.
    while (pending_words.size() < 550) begin
      phase_kind = $urandom_range(2);
      phase_len  = $urandom_range(8, 30);
      for (int i = 0; i < phase_len; i++) begin
        logic [1:0] act;
        case (phase_kind)
          0:       act = pick_action(78, 8, 9);
          1:       act = pick_action(12, 68, 15);
          default: act = pick_action(42, 33, 20);
        endcase
        add_word(act, random_rec(),
                 (i == 0) && (pending_words.size() < 30 || $urandom_range(5) == 0));
      end
    end

    rst_n <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() != 0 || in_tvalid || awaited_replies.size() != 0)
      @(posedge clk);
    // The wait below lets any stray result word show up.
    repeat (8) @(posedge clk);

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
